### rtl/ptc_pkg.sv
package ptc_pkg;

	localparam int unsigned IdW      = 11;
	localparam int unsigned WordW    = 16;
	localparam int unsigned ScaleW   = 8;
	localparam int unsigned PctW     = 7;
	localparam int unsigned ModeW    = 2;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned DivSteps = ScaleW;
	localparam int unsigned DivCntW  = $clog2(DivSteps);
	localparam int unsigned ProdW    = WordW + ScaleW;

	localparam logic [IdW-1:0] FID_NEUTRAL = 11'h030;
	localparam logic [IdW-1:0] FID_DRIVE   = 11'h040;
	localparam logic [IdW-1:0] FID_TRAINER = 11'h050;
	localparam logic [IdW-1:0] FID_PEDAL   = 11'h125;

	localparam logic [IdW-1:0] RID_NEUTRAL = 11'h031;
	localparam logic [IdW-1:0] RID_DRIVE   = 11'h041;
	localparam logic [IdW-1:0] RID_TRAINER = 11'h051;
	localparam logic [IdW-1:0] RID_PEDAL   = 11'h110;

	localparam logic [ModeW-1:0] MODE_NEUTRAL = 2'd0;
	localparam logic [ModeW-1:0] MODE_DRIVE   = 2'd1;
	localparam logic [ModeW-1:0] MODE_TRAINER = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_PRI_MIN = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PRI_MAX = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SEC_MIN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SEC_MAX = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DRV_SCL = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TRN_SCL = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_WARN    = 3'd6;

	localparam logic [WordW-1:0]  RST_PRI_MIN = 16'd0;
	localparam logic [WordW-1:0]  RST_PRI_MAX = 16'd4095;
	localparam logic [WordW-1:0]  RST_SEC_MIN = 16'd0;
	localparam logic [WordW-1:0]  RST_SEC_MAX = 16'd4095;
	localparam logic [ScaleW-1:0] RST_DRV_SCL = 8'd100;
	localparam logic [ScaleW-1:0] RST_TRN_SCL = 8'd50;
	localparam logic [ScaleW-1:0] RST_WARN    = 8'd30;

	localparam logic [ScaleW-1:0] PCT_FACTOR = 8'd100;

	typedef struct packed {
		logic              start;
		logic [WordW-1:0]  v;
		logic [WordW-1:0]  lo;
		logic [WordW-1:0]  hi;
		logic [ScaleW-1:0] factor;
	} ptc_scale_req_t;

	typedef struct packed {
		logic              done;
		logic [ScaleW-1:0] quo;
	} ptc_scale_rsp_t;

	typedef struct packed {
		logic [IdW-1:0]    reply_id;
		logic              reply_remote;
		logic [ModeW-1:0]  drive_mode;
		logic              buzzer_pulse;
		logic              pedal_frame;
		logic [ScaleW-1:0] torque_cmd;
		logic [PctW-1:0]   secondary_percent;
		logic [ScaleW-1:0] brake_level;
		logic              warning;
		logic              range_error;
	} ptc_result_t;

endpackage

### rtl/ptc_if.sv
interface ptc_frame_if import ptc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IdW-1:0]   frame_id;
	logic [WordW-1:0] accel_primary_raw;
	logic [WordW-1:0] accel_secondary_raw;
	logic [WordW-1:0] brake_raw;

	modport source (
		output valid, frame_id, accel_primary_raw, accel_secondary_raw, brake_raw,
		input  ready
	);
	modport sink (
		input  valid, frame_id, accel_primary_raw, accel_secondary_raw, brake_raw,
		output ready
	);
endinterface

interface ptc_reply_if import ptc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IdW-1:0]    reply_id;
	logic              reply_remote;
	logic [ModeW-1:0]  drive_mode;
	logic              buzzer_pulse;
	logic              pedal_frame;
	logic [ScaleW-1:0] torque_cmd;
	logic [PctW-1:0]   secondary_percent;
	logic [ScaleW-1:0] brake_level;
	logic              warning;
	logic              range_error;

	modport source (
		output valid, reply_id, reply_remote, drive_mode, buzzer_pulse, pedal_frame,
		       torque_cmd, secondary_percent, brake_level, warning, range_error,
		input  ready
	);
	modport sink (
		input  valid, reply_id, reply_remote, drive_mode, buzzer_pulse, pedal_frame,
		       torque_cmd, secondary_percent, brake_level, warning, range_error,
		output ready
	);
endinterface

### rtl/ptc_scale.sv
module ptc_scale import ptc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  ptc_scale_req_t req,
	output ptc_scale_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [WordW-1:0]   rem_q;
	logic [WordW-1:0]   den_q;
	logic [ScaleW-1:0]  quo_q;

	logic [WordW-1:0] v_hi;
	logic [WordW-1:0] v_cl;
	logic [WordW-1:0] span;
	logic [WordW-1:0] offs;
	logic [ProdW-1:0] prod;
	logic [WordW:0]   trial;
	logic [WordW:0]   trial_sub;
	logic             fits;

	always_comb begin
		v_hi      = (req.v > req.hi) ? req.hi : req.v;
		v_cl      = (v_hi < req.lo) ? req.lo : v_hi;
		offs      = v_cl - req.lo;
		span      = req.hi - req.lo;
		prod      = ProdW'(req.factor) * ProdW'(offs);
		trial     = {rem_q, quo_q[ScaleW-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivSteps - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= prod[ProdW-1:ScaleW];
			quo_q <= prod[ScaleW-1:0];
			den_q <= span;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[WordW-1:0] : trial[WordW-1:0];
			quo_q <= {quo_q[ScaleW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### rtl/pedal_torque_command_unit.sv
// Pedal torque command unit.
// frames: valid/ready channel of received bus frames (identifier and three pedal words).
// replies: valid/ready channel of results, at most one per frame.
// wr_en/wr_index/wr_data: register writes, taken at any edge with wr_en high; write only
// while idle. Indexes beyond the last register are ignored.
// Frames 0x30, 0x40 and 0x50 update the drive mode and give a remote reply. Frame 0x125
// runs three scalings (primary, brake, secondary) one after another through one clamp,
// 8x16 multiply and 8-step restoring divider. Other identifiers are dropped in the accept
// cycle. One frame is worked on at a time; frames.ready is high only while idle, so a
// pedal frame holds the unit through all three divider passes.
// The finished reply sits in an output register; while the receiver stalls it holds, and
// a later result waits until the register is taken, with frames.ready low meanwhile.
// Reset clears the mode to neutral, restores register defaults and empties the output.
module pedal_torque_command_unit import ptc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [CfgIdxW-1:0]  wr_index,
	input  logic [CfgDataW-1:0] wr_data,
	ptc_frame_if.sink           frames,
	ptc_reply_if.source         replies
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_HOLD  = 3'd4;

	localparam logic [1:0] OP_PRI = 2'd0;
	localparam logic [1:0] OP_BRK = 2'd1;
	localparam logic [1:0] OP_SEC = 2'd2;

	logic [WordW-1:0]  pri_min_q, pri_max_q, sec_min_q, sec_max_q;
	logic [ScaleW-1:0] drv_scl_q, trn_scl_q, warn_q;

	logic [2:0]       state_q;
	logic [1:0]       op_q;
	logic [ModeW-1:0] mode_q;
	logic             out_valid_q;

	logic [WordW-1:0]  a1_q, a2_q, br_q;
	logic [ScaleW-1:0] tq_q, bq_q;
	logic [PctW-1:0]   sq_q;
	ptc_result_t       res_q;
	ptc_result_t       out_q;
	ptc_result_t       res_acc;

	logic              acc;
	logic              is_mode;
	logic              is_pedal;
	logic [ModeW-1:0]  mode_nxt;
	logic              buzz_nxt;
	logic [IdW-1:0]    rid;
	logic              load;
	logic [ScaleW-1:0] factor;
	logic              pri_err, sec_err;
	logic [ScaleW-1:0] t_eff, b_eff;
	logic [PctW-1:0]   s_eff;
	logic              warn;

	ptc_scale_req_t sc_req;
	ptc_scale_rsp_t sc_rsp;

	ptc_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sc_req),
		.rsp    (sc_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pri_min_q <= RST_PRI_MIN;
			pri_max_q <= RST_PRI_MAX;
			sec_min_q <= RST_SEC_MIN;
			sec_max_q <= RST_SEC_MAX;
			drv_scl_q <= RST_DRV_SCL;
			trn_scl_q <= RST_TRN_SCL;
			warn_q    <= RST_WARN;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PRI_MIN: pri_min_q <= wr_data[WordW-1:0];
				REG_PRI_MAX: pri_max_q <= wr_data[WordW-1:0];
				REG_SEC_MIN: sec_min_q <= wr_data[WordW-1:0];
				REG_SEC_MAX: sec_max_q <= wr_data[WordW-1:0];
				REG_DRV_SCL: drv_scl_q <= wr_data[ScaleW-1:0];
				REG_TRN_SCL: trn_scl_q <= wr_data[ScaleW-1:0];
				REG_WARN:    warn_q    <= wr_data[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	assign frames.ready = (state_q == S_IDLE);
	assign acc          = frames.valid & frames.ready;
	assign is_mode      = (frames.frame_id == FID_NEUTRAL) || (frames.frame_id == FID_DRIVE)
	                      || (frames.frame_id == FID_TRAINER);
	assign is_pedal     = (frames.frame_id == FID_PEDAL);
	assign load         = (state_q == S_HOLD) && (!out_valid_q || replies.ready);

	always_comb begin
		buzz_nxt = 1'b0;
		if (frames.frame_id == FID_NEUTRAL) begin
			mode_nxt = MODE_NEUTRAL;
		end else if (mode_q == MODE_NEUTRAL) begin
			mode_nxt = (frames.frame_id == FID_DRIVE) ? MODE_DRIVE : MODE_TRAINER;
			buzz_nxt = 1'b1;
		end else begin
			mode_nxt = mode_q;
		end
		unique case (mode_nxt)
			MODE_DRIVE:   rid = RID_DRIVE;
			MODE_TRAINER: rid = RID_TRAINER;
			default:      rid = RID_NEUTRAL;
		endcase
	end

	always_comb begin
		res_acc              = '0;
		res_acc.reply_id     = is_pedal ? RID_PEDAL : rid;
		res_acc.reply_remote = is_mode;
		res_acc.drive_mode   = is_mode ? mode_nxt : mode_q;
		res_acc.buzzer_pulse = is_mode & buzz_nxt;
		res_acc.pedal_frame  = is_pedal;
	end

	always_comb begin
		unique case (mode_q)
			MODE_DRIVE:   factor = drv_scl_q;
			MODE_TRAINER: factor = trn_scl_q;
			default:      factor = '0;
		endcase
		sc_req.start = (state_q == S_ISSUE);
		unique case (op_q)
			OP_BRK: begin
				sc_req.v      = br_q;
				sc_req.lo     = pri_min_q;
				sc_req.hi     = pri_max_q;
				sc_req.factor = factor;
			end
			OP_SEC: begin
				sc_req.v      = a2_q;
				sc_req.lo     = sec_min_q;
				sc_req.hi     = sec_max_q;
				sc_req.factor = PCT_FACTOR;
			end
			default: begin
				sc_req.v      = a1_q;
				sc_req.lo     = pri_min_q;
				sc_req.hi     = pri_max_q;
				sc_req.factor = factor;
			end
		endcase
	end

	always_comb begin
		pri_err = !(pri_max_q > pri_min_q);
		sec_err = !(sec_max_q > sec_min_q);
		t_eff   = pri_err ? '0 : tq_q;
		b_eff   = pri_err ? '0 : bq_q;
		s_eff   = sec_err ? '0 : sq_q;
		warn    = (t_eff > warn_q) && (ScaleW'(s_eff) > warn_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_PRI;
			mode_q      <= MODE_NEUTRAL;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (replies.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && is_mode) begin
						mode_q  <= mode_nxt;
						state_q <= S_HOLD;
					end else if (acc && is_pedal) begin
						op_q    <= OP_PRI;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (sc_rsp.done) begin
						if (op_q == OP_SEC) begin
							state_q <= S_FIN;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_FIN: state_q <= S_HOLD;
				S_HOLD: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			a1_q  <= frames.accel_primary_raw;
			a2_q  <= frames.accel_secondary_raw;
			br_q  <= frames.brake_raw;
			res_q <= res_acc;
		end
		if ((state_q == S_WAIT) && sc_rsp.done) begin
			unique case (op_q)
				OP_BRK:  bq_q <= sc_rsp.quo;
				OP_SEC:  sq_q <= sc_rsp.quo[PctW-1:0];
				default: tq_q <= sc_rsp.quo;
			endcase
		end
		if (state_q == S_FIN) begin
			res_q.torque_cmd        <= warn ? '0 : t_eff;
			res_q.brake_level       <= b_eff;
			res_q.secondary_percent <= s_eff;
			res_q.warning           <= warn;
			res_q.range_error       <= pri_err | sec_err;
		end
		if (load) begin
			out_q <= res_q;
		end
	end

	assign replies.valid             = out_valid_q;
	assign replies.reply_id          = out_q.reply_id;
	assign replies.reply_remote      = out_q.reply_remote;
	assign replies.drive_mode        = out_q.drive_mode;
	assign replies.buzzer_pulse      = out_q.buzzer_pulse;
	assign replies.pedal_frame       = out_q.pedal_frame;
	assign replies.torque_cmd        = out_q.torque_cmd;
	assign replies.secondary_percent = out_q.secondary_percent;
	assign replies.brake_level       = out_q.brake_level;
	assign replies.warning           = out_q.warning;
	assign replies.range_error       = out_q.range_error;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sc_rsp.done |-> (state_q == S_WAIT))
		else $error("divider result outside wait state");

	a_mode_to_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_mode) |=> (state_q == S_HOLD))
		else $error("mode frame did not go straight to reply");

	a_pedal_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.pedal_frame) |-> (out_q.reply_id == RID_PEDAL))
		else $error("pedal reply with wrong identifier");

	a_warn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.warning) |-> (out_q.torque_cmd == '0))
		else $error("torque not zero under warning");
`endif

endmodule
